FILE: hdl/s512_pkg.sv
`timescale 1ns / 1ps
package s512_pkg;

    localparam int WORD_W  = 64;
    localparam int BV_W    = 4;
    localparam int ROUNDS  = 80;
    localparam int BLK_WORDS = 16;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    function automatic word_t iv_word(input logic mode, input logic [2:0] idx);
        word_t r;
        r = '0;
        if (mode)
        begin
            unique case (idx)
                3'd0: r = 64'hcbbb9d5dc1059ed8;
                3'd1: r = 64'h629a292a367cd507;
                3'd2: r = 64'h9159015a3070dd17;
                3'd3: r = 64'h152fecd8f70e5939;
                3'd4: r = 64'h67332667ffc00b31;
                3'd5: r = 64'h8eb44a8768581511;
                3'd6: r = 64'hdb0c2e0d64f98fa7;
                3'd7: r = 64'h47b5481dbefa4fa4;
                default: r = '0;
            endcase
        end
        else
        begin
            unique case (idx)
                3'd0: r = 64'h6a09e667f3bcc908;
                3'd1: r = 64'hbb67ae8584caa73b;
                3'd2: r = 64'h3c6ef372fe94f82b;
                3'd3: r = 64'ha54ff53a5f1d36f1;
                3'd4: r = 64'h510e527fade682d1;
                3'd5: r = 64'h9b05688c2b3e6c1f;
                3'd6: r = 64'h1f83d9abfb41bd6b;
                3'd7: r = 64'h5be0cd19137e2179;
                default: r = '0;
            endcase
        end
        return r;
    endfunction

    function automatic word_t round_k(input logic [6:0] r);
        word_t k;
        k = '0;
        unique case (r)
            7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

FILE: hdl/s512_if.sv
`timescale 1ns / 1ps
interface s512_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_word;
    logic [3:0]  bytes_valid;
    logic        last_item;
    modport source  (output valid, message_word, bytes_valid, last_item, input ready);
    modport sink    (input valid, message_word, bytes_valid, last_item, output ready);
    modport monitor (input valid, ready, message_word, bytes_valid, last_item);
endinterface

interface s512_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic        digest_last;
    modport source  (output valid, digest_word, digest_last, input ready);
    modport sink    (input valid, digest_word, digest_last, output ready);
    modport monitor (input valid, ready, digest_word, digest_last);
endinterface

FILE: hdl/sha384_sha512_digest.sv
`timescale 1ns / 1ps
// Channel   | Dir | Payload                                     | Handshake
// in_ch     | in  | message_word[64], bytes_valid[4], last_item | valid/ready
// out_ch    | out | digest_word[64], digest_last                | valid/ready
// cfg       | in  | cfg_wdata[1] (digest_mode)                  | cfg_we
//
// A non-final word is taken while the block buffer has room.
// The word that completes a block stalls the input while the schedule taps
// and working words load, the rounds run one after another and the result
// is folded into the chaining memory.
// A final word is followed by padding words written one a cycle (at most 18),
// one or two compressions, then 8 or 6 digest words, each held until taken.
// Reset and a mode write reload the initial values into the chaining memory.
module sha384_sha512_digest
    import s512_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    s512_in_if.sink      in_ch,
    s512_out_if.source   out_ch
);

    // Block buffer: one memory, registered read.
    word_t  wmem [BLK_WORDS];
    word_t  wrd_reg;
    // Chaining words in their own memory, one read and one write a cycle.
    word_t  cmem [8];
    word_t  crd_reg;

    state_t      state_reg, state_next;
    logic        mode_reg;
    logic [3:0]  fill_reg;     // words held in the block buffer
    logic [63:0] nbytes_reg;
    logic [6:0]  rnd_reg;
    logic [4:0]  idx_reg;      // load/fold/emit/init counter
    logic        init_reg;     // chaining memory reload in progress
    logic        fin_reg;      // the message is being finished
    logic        p80_reg;      // a full final word still owes the pad byte word
    logic        skip_reg;     // the length does not fit in the current block
    logic        lendone_reg;  // the length words are in the buffer
    word_t       v_reg [8];
    word_t       sh [BLK_WORDS];
    word_t       w_reg;

    logic        in_acc, out_acc, busy;
    word_t       pad_word;
    logic [3:0]  nb;
    logic [4:0]  emit_n;

    assign emit_n  = mode_reg ? 5'd6 : 5'd8;
    assign busy    = init_reg || state_reg != ST_IDLE;
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;

    // Final word: keep the valid leading bytes and place the pad byte after them.
    assign nb = (in_ch.bytes_valid > 4'd8) ? 4'd8 : in_ch.bytes_valid;
    always_comb
    begin
        word_t keep;
        keep = (nb == 4'd0) ? '0 : ~((64'd1 << (7'd64 - {nb, 3'b000})) - 64'd1);
        pad_word = (in_ch.message_word & keep) | (64'h80 << (7'd56 - {nb, 3'b000}));
        if (nb == 4'd8)
            pad_word = in_ch.message_word;
    end

    // Round logic. The taps hold the 16-word schedule window and shift by one
    // word per round; the schedule word of the next round is registered into
    // w_reg during the current round to keep the adder chain of a round short.
    word_t  w_sched, s0w, s1w, t1, t2, sig1, sig0;
    always_comb
    begin
        s0w = rotr(sh[2], 1) ^ rotr(sh[2], 8) ^ (sh[2] >> 7);
        s1w = rotr(sh[15], 19) ^ rotr(sh[15], 61) ^ (sh[15] >> 6);
        w_sched = sh[1] + s0w + sh[10] + s1w;
        sig1 = rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41);
        t1 = v_reg[7] + sig1 + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + round_k(rnd_reg) + w_reg;
        sig0 = rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39);
        t2 = sig0 + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Word to write into the block buffer this cycle. Padding puts the pad
    // byte word first when it is owed, then zeros, then the two length words
    // at the last two positions of the block that has room for them.
    logic   wwe;
    word_t  wwd;
    always_comb
    begin
        wwe = 1'b0;
        wwd = '0;
        if (in_acc)
        begin
            wwe = 1'b1;
            wwd = in_ch.last_item ? pad_word : in_ch.message_word;
        end
        else if (state_reg == ST_PAD)
        begin
            wwe = 1'b1;
            if (p80_reg)
                wwd = 64'h8000_0000_0000_0000;
            else if (!skip_reg && fill_reg == 4'd14)
                wwd = {61'd0, nbytes_reg[63:61]};
            else if (!skip_reg && fill_reg == 4'd15)
                wwd = {nbytes_reg[60:0], 3'b000};
            else
                wwd = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wwe)
            wmem[fill_reg] <= wwd;
        wrd_reg <= wmem[idx_reg[3:0]];
    end

    // Chaining memory port.
    logic       cwe;
    logic [2:0] cwa, cra;
    word_t      cwd;
    always_comb
    begin
        cwe = 1'b0;
        cwa = idx_reg[2:0];
        cwd = '0;
        cra = idx_reg[2:0];
        if (init_reg)
        begin
            cwe = 1'b1;
            cwd = iv_word(mode_reg, idx_reg[2:0]);
        end
        else if (state_reg == ST_FOLD && idx_reg != 5'd0)
        begin
            cwe = 1'b1;
            cwa = 3'(idx_reg - 5'd1);
            cwd = crd_reg + v_reg[0];
        end
        else if (state_reg == ST_EMIT && out_acc)
            cra = 3'(idx_reg + 5'd1);
    end

    always_ff @(posedge clk)
    begin
        if (cwe)
            cmem[cwa] <= cwd;
        crd_reg <= cmem[cra];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc && fill_reg == 4'd15)
                    state_next = ST_LOAD;
                else if (in_acc && in_ch.last_item)
                    state_next = ST_PAD;
            ST_PAD:
                if (fill_reg == 4'd15)
                    state_next = ST_LOAD;
            ST_LOAD:
                if (idx_reg == 5'd16)
                    state_next = ST_ROUND;
            ST_ROUND:
                if (rnd_reg == 7'(ROUNDS-1))
                    state_next = ST_FOLD;
            ST_FOLD:
                if (idx_reg == 5'd8)
                    state_next = !fin_reg ? ST_IDLE : (lendone_reg ? ST_EMIT : ST_PAD);
            ST_EMIT:
                if (out_acc && idx_reg == emit_n - 5'd1)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // The digest word is read from the chaining memory one word ahead, so it
    // stays on the port while the receiver stalls.
    always_comb
    begin
        in_ch.ready        = state_reg == ST_IDLE && !init_reg && !cfg_we;
        out_ch.valid       = state_reg == ST_EMIT;
        out_ch.digest_word = crd_reg;
        out_ch.digest_last = idx_reg == emit_n - 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mode_reg    <= 1'b0;
            fill_reg    <= '0;
            nbytes_reg  <= '0;
            rnd_reg     <= '0;
            idx_reg     <= '0;
            init_reg    <= 1'b1;
            fin_reg     <= 1'b0;
            p80_reg     <= 1'b0;
            skip_reg    <= 1'b0;
            lendone_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            // A mode write drops any message in progress.
            state_reg   <= ST_IDLE;
            mode_reg    <= cfg_wdata;
            init_reg    <= 1'b1;
            idx_reg     <= '0;
            rnd_reg     <= '0;
            fill_reg    <= '0;
            nbytes_reg  <= '0;
            fin_reg     <= 1'b0;
            p80_reg     <= 1'b0;
            skip_reg    <= 1'b0;
            lendone_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wwe)
                fill_reg <= fill_reg + 4'd1;
            if (init_reg)
            begin
                if (idx_reg == 5'd7)
                begin
                    idx_reg  <= '0;
                    init_reg <= 1'b0;
                end
                else
                    idx_reg <= idx_reg + 5'd1;
            end
            if (in_acc)
            begin
                if (in_ch.last_item)
                begin
                    nbytes_reg <= nbytes_reg + 64'(nb);
                    fin_reg    <= 1'b1;
                    p80_reg    <= nb == 4'd8;
                    // The pad byte in the second to last slot leaves no room
                    // for the length in this block.
                    skip_reg   <= nb != 4'd8 && fill_reg == 4'd14;
                end
                else
                    nbytes_reg <= nbytes_reg + 64'd8;
            end
            unique case (state_reg)
                ST_IDLE: ;
                ST_PAD:
                begin
                    if (p80_reg)
                    begin
                        p80_reg  <= 1'b0;
                        skip_reg <= fill_reg == 4'd14;
                    end
                    else if (fill_reg == 4'd15)
                    begin
                        lendone_reg <= !skip_reg;
                        skip_reg    <= 1'b0;
                    end
                end
                ST_LOAD:
                    idx_reg <= (idx_reg == 5'd16) ? 5'd0 : idx_reg + 5'd1;
                ST_ROUND:
                    rnd_reg <= (rnd_reg == 7'(ROUNDS-1)) ? 7'd0 : rnd_reg + 7'd1;
                ST_FOLD:
                    idx_reg <= (idx_reg == 5'd8) ? 5'd0 : idx_reg + 5'd1;
                ST_EMIT:
                begin
                    if (out_acc)
                    begin
                        if (idx_reg == emit_n - 5'd1)
                        begin
                            idx_reg     <= '0;
                            init_reg    <= 1'b1;
                            fin_reg     <= 1'b0;
                            lendone_reg <= 1'b0;
                            nbytes_reg  <= '0;
                        end
                        else
                            idx_reg <= idx_reg + 5'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Taps and working variables. During the load the buffer words and the
    // chaining words shift in one per cycle; the fold rotates the working
    // words past the chaining memory adder.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            if (idx_reg != 5'd0)
            begin
                for (int i = 0; i < BLK_WORDS-1; i++)
                    sh[i] <= sh[i+1];
                sh[BLK_WORDS-1] <= wrd_reg;
            end
            if (idx_reg != 5'd0 && idx_reg <= 5'd8)
            begin
                for (int i = 0; i < 7; i++)
                    v_reg[i] <= v_reg[i+1];
                v_reg[7] <= crd_reg;
            end
            if (idx_reg == 5'd16)
                w_reg <= sh[1];
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < BLK_WORDS-1; i++)
                sh[i] <= sh[i+1];
            sh[BLK_WORDS-1] <= w_reg;
            w_reg <= (rnd_reg < 7'd15) ? sh[1] : w_sched;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else if (state_reg == ST_FOLD && idx_reg != 5'd0)
        begin
            for (int i = 0; i < 7; i++)
                v_reg[i] <= v_reg[i+1];
            v_reg[7] <= v_reg[0];
        end
    end

    property p_no_in_when_busy;
        @(posedge clk) disable iff (!rst_n) busy |-> !in_acc;
    endproperty
    a_no_in_when_busy: assert property (p_no_in_when_busy) else $error("input taken while busy");

    property p_out_only_emit;
        @(posedge clk) disable iff (!rst_n) out_ch.valid |-> state_reg == ST_EMIT;
    endproperty
    a_out_only_emit: assert property (p_out_only_emit) else $error("output outside emit");

    property p_round_range;
        @(posedge clk) disable iff (!rst_n) state_reg == ST_ROUND |-> rnd_reg < 7'd80;
    endproperty
    a_round_range: assert property (p_round_range) else $error("round counter overrun");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
            out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.digest_word);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("digest word dropped while stalled");

endmodule
